@@ rtl/core/spl_pkg.sv @@
// Package for the sorted priority list: transfer structs, entry type, status codes,
// the key ordering function and the controller state type.
// It has no dependencies; every other file in rtl/core refers to it.
package spl_pkg;

   localparam int DEFAULT_CAPACITY = 16;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_SWAP   = 1'b1;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_FULL      = 3'd1;
   localparam logic [2:0] STATUS_SAME      = 3'd2;
   localparam logic [2:0] STATUS_NO_FIRST  = 3'd3;
   localparam logic [2:0] STATUS_NO_SECOND = 3'd4;

   typedef struct packed {
      logic               func;
      logic [3:0]         priority_req;
      logic signed [31:0] value;
      logic [3:0]         first_priority;
      logic [3:0]         second_priority;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic               has_entry;
      logic [3:0]         out_priority;
      logic signed [31:0] out_value;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [3:0]         prio;
      logic signed [31:0] val;
   } entry_type;

   // Ring movement requested from the cells. With pop the whole ring moves one cell
   // toward cell 0 and the tail takes the broadcast entry; without pop the broadcast
   // entry is appended behind the current tail.
   typedef struct packed {
      logic pop;
      logic push;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIND,
      ST_EMIT
   } state_type;

   // True when key a is strictly below key b: priority first, then signed value.
   function automatic logic key_below(entry_type a, entry_type b);
      logic result;
      if (a.prio != b.prio) begin
         result = (a.prio < b.prio);
      end else begin
         result = (a.val < b.val);
      end
      return result;
   endfunction

endpackage

@@ rtl/core/sorted_priority_list.sv @@
// Top level of the sorted priority list: a ring of spl_cell storage cells with a
// controller that searches, inserts, swaps and lists the entries through cell 0.
// Depends on spl_pkg and spl_cell.
//
//   Channel   Direction  Payload                Handshake
//   req_      in         spl_pkg::req_type      req_valid / req_stall
//   rsp_      out        spl_pkg::rsp_type      rsp_valid / rsp_stall
//
// Flow: an item is taken while the controller is idle. An insert then lists one entry
// per cycle while the result is not stalled: the old count plus one, or the old count on
// a full list. A swap of two different priorities on a nonempty list first turns the
// ring once and then lists; other swaps list at once. A swap on an empty list lists one
// marker. Reset clears the state machine, the entry count and the result valid; cell
// contents are only read below the count. A result stall halts listing, not the search.
module sorted_priority_list #(
   parameter int CAPACITY = spl_pkg::DEFAULT_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  spl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output spl_pkg::rsp_type rsp_data
);

   localparam int CW = $clog2(CAPACITY + 1);

   // The ring holds the list as a queue. During a listing, the old entries not yet
   // listed sit at the head and every listed entry is appended at the tail, so
   // after one full turn the new list again starts at cell 0.
   spl_pkg::entry_type     cell_entry [CAPACITY];
   spl_pkg::cell_ctrl_type cell_ctrl;
   spl_pkg::entry_type     tail_entry;
   spl_pkg::entry_type     head;

   spl_pkg::state_type state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      old_count_ff, old_count_in;
   logic [CW-1:0]      step_ff, step_in;
   spl_pkg::req_type   req_ff, req_in;
   logic [2:0]         status_ff, status_in;
   logic               inserted_ff, inserted_in;
   logic               seen_a_ff, seen_a_in;
   logic               seen_b_ff, seen_b_in;
   spl_pkg::entry_type ent_a_ff, ent_a_in;
   spl_pkg::entry_type ent_b_ff, ent_b_in;
   logic               rsp_valid_ff, rsp_valid_in;
   spl_pkg::rsp_type   rsp_ff, rsp_in;

   for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
      spl_pkg::entry_type right;
      if (k == CAPACITY - 1) begin : g_end
         assign right = cell_entry[k];
      end else begin : g_mid
         assign right = cell_entry[k + 1];
      end
      spl_cell #(
         .CAPACITY (CAPACITY),
         .INDEX    (k)
      ) u_cell (
         .clock     (clock),
         .ctrl      (cell_ctrl),
         .count     (count_ff),
         .right_in  (right),
         .tail_in   (tail_entry),
         .entry_out (cell_entry[k])
      );
   end

   assign head = cell_entry[0];

   // Decisions shared by the state machine and the datapath.
   spl_pkg::entry_type new_entry;
   spl_pkg::entry_type emit_entry;
   logic               out_free;
   logic               swap_search;
   logic               find_done;
   logic               match_a;
   logic               match_b;
   logic               old_left;
   logic               ins_pending;
   logic               ins_here;
   logic               swapping;
   logic               hit_a;
   logic               hit_b;
   logic               emit_fire;
   logic               emit_last;

   always_comb begin
      new_entry.prio = req_ff.priority_req;
      new_entry.val  = req_ff.value;
      out_free       = !rsp_valid_ff || !rsp_stall;
      swap_search    = (req_data.func == spl_pkg::FUNC_SWAP) &&
                       (req_data.first_priority != req_data.second_priority) &&
                       (count_ff != '0);
      find_done      = ((step_ff + CW'(1)) == count_ff);
      match_a        = (head.prio == req_ff.first_priority) && !seen_a_ff;
      match_b        = (head.prio == req_ff.second_priority) && !seen_b_ff;

      // The new entry goes in front of old entry 0 if it is strictly below it, and
      // in front of any later old entry that is not strictly below the new one.
      old_left    = (step_ff != old_count_ff);
      ins_pending = (req_ff.func == spl_pkg::FUNC_INSERT) && !inserted_ff;
      if (!ins_pending) begin
         ins_here = 1'b0;
      end else if (!old_left) begin
         ins_here = 1'b1;
      end else if (step_ff == '0) begin
         ins_here = spl_pkg::key_below(new_entry, head);
      end else begin
         ins_here = !spl_pkg::key_below(head, new_entry);
      end

      swapping = (req_ff.func == spl_pkg::FUNC_SWAP) && (status_ff == spl_pkg::STATUS_OK);
      hit_a    = swapping && old_left && match_a;
      hit_b    = swapping && old_left && match_b;

      if (ins_here) begin
         emit_entry = new_entry;
      end else if (hit_a) begin
         emit_entry = ent_b_ff;
      end else if (hit_b) begin
         emit_entry = ent_a_ff;
      end else begin
         emit_entry = head;
      end

      if (ins_here) begin
         emit_last = !old_left;
      end else if (old_left) begin
         emit_last = ((step_ff + CW'(1)) == old_count_ff) && !ins_pending;
      end else begin
         emit_last = 1'b1;
      end

      emit_fire = (state_ff == spl_pkg::ST_EMIT) && out_free;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spl_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = swap_search ? spl_pkg::ST_FIND : spl_pkg::ST_EMIT;
            end
         end
         spl_pkg::ST_FIND: begin
            if (find_done) begin
               state_in = spl_pkg::ST_EMIT;
            end
         end
         spl_pkg::ST_EMIT: begin
            if (emit_fire && emit_last) begin
               state_in = spl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spl_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath and ring control.
   always_comb begin
      count_in     = count_ff;
      old_count_in = old_count_ff;
      step_in      = step_ff;
      req_in       = req_ff;
      status_in    = status_ff;
      inserted_in  = inserted_ff;
      seen_a_in    = seen_a_ff;
      seen_b_in    = seen_b_ff;
      ent_a_in     = ent_a_ff;
      ent_b_in     = ent_b_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cell_ctrl    = '0;
      tail_entry   = head;

      case (state_ff)
         spl_pkg::ST_IDLE: begin
            if (req_valid) begin
               req_in       = req_data;
               step_in      = '0;
               old_count_in = count_ff;
               inserted_in  = 1'b0;
               seen_a_in    = 1'b0;
               seen_b_in    = 1'b0;
               if (req_data.func == spl_pkg::FUNC_INSERT) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     status_in   = spl_pkg::STATUS_FULL;
                     inserted_in = 1'b1;
                  end else begin
                     status_in = spl_pkg::STATUS_OK;
                  end
               end else if (req_data.first_priority == req_data.second_priority) begin
                  status_in = spl_pkg::STATUS_SAME;
               end else if (count_ff == '0) begin
                  status_in = spl_pkg::STATUS_NO_FIRST;
               end else begin
                  status_in = spl_pkg::STATUS_OK;
               end
            end
         end
         spl_pkg::ST_FIND: begin
            // One full turn of the ring; remember the first entry of each of the two requested priorities.
            cell_ctrl.pop  = 1'b1;
            cell_ctrl.push = 1'b1;
            tail_entry     = head;
            if (match_a) begin
               seen_a_in = 1'b1;
               ent_a_in  = head;
            end
            if (match_b) begin
               seen_b_in = 1'b1;
               ent_b_in  = head;
            end
            if (find_done) begin
               step_in   = '0;
               seen_a_in = 1'b0;
               seen_b_in = 1'b0;
               if (!(seen_a_ff || match_a)) begin
                  status_in = spl_pkg::STATUS_NO_FIRST;
               end else if (!(seen_b_ff || match_b)) begin
                  status_in = spl_pkg::STATUS_NO_SECOND;
               end else begin
                  status_in = spl_pkg::STATUS_OK;
               end
            end else begin
               step_in = step_ff + CW'(1);
            end
         end
         spl_pkg::ST_EMIT: begin
            if (emit_fire) begin
               rsp_valid_in     = 1'b1;
               rsp_in.status    = status_ff;
               rsp_in.has_entry = ins_here || old_left;
               rsp_in.last      = emit_last;
               if (ins_here || old_left) begin
                  rsp_in.out_priority = emit_entry.prio;
                  rsp_in.out_value    = emit_entry.val;
               end else begin
                  rsp_in.out_priority = '0;
                  rsp_in.out_value    = '0;
               end
               tail_entry = emit_entry;
               if (ins_here) begin
                  cell_ctrl.push = 1'b1;
                  count_in       = count_ff + CW'(1);
                  inserted_in    = 1'b1;
               end else if (old_left) begin
                  cell_ctrl.pop  = 1'b1;
                  cell_ctrl.push = 1'b1;
                  step_in        = step_ff + CW'(1);
                  if (hit_a) begin
                     seen_a_in = 1'b1;
                  end
                  if (hit_b) begin
                     seen_b_in = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spl_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      old_count_ff <= old_count_in;
      step_ff      <= step_in;
      req_ff       <= req_in;
      status_ff    <= status_in;
      inserted_ff  <= inserted_in;
      seen_a_ff    <= seen_a_in;
      seen_b_ff    <= seen_b_in;
      ent_a_ff     <= ent_a_in;
      ent_b_ff     <= ent_b_in;
      rsp_ff       <= rsp_in;
   end

   assign req_stall = (state_ff != spl_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_count_grows_by_one : assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && (count_ff != $past(count_ff)) |-> (count_ff == $past(count_ff) + CW'(1)))
      else $error("entry count changed by other than one");

   a_find_nonempty : assert property (@(posedge clock) disable iff (reset)
      (state_ff == spl_pkg::ST_FIND) |-> (count_ff != '0) && (step_ff < count_ff))
      else $error("search pass on an empty ring or past its end");

   a_empty_marker_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.has_entry |-> rsp_ff.last && (count_ff == '0))
      else $error("empty marker while entries are held");
`endif

endmodule

@@ rtl/core/spl_cell.sv @@
// One storage cell of the sorted priority list ring.
// Depends on spl_pkg for the entry and control types.
module spl_cell #(
   parameter int CAPACITY = spl_pkg::DEFAULT_CAPACITY,
   parameter int INDEX    = 0
) (
   input  logic                       clock,
   input  spl_pkg::cell_ctrl_type     ctrl,
   input  logic [$clog2(CAPACITY+1)-1:0] count,
   input  spl_pkg::entry_type         right_in,
   input  spl_pkg::entry_type         tail_in,
   output spl_pkg::entry_type         entry_out
);

   localparam int CW = $clog2(CAPACITY + 1);

   spl_pkg::entry_type entry_ff;
   spl_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push) begin
         if (ctrl.pop) begin
            if (CW'(INDEX + 1) == count) begin
               entry_in = tail_in;
            end else if (CW'(INDEX + 1) < count) begin
               entry_in = right_in;
            end
         end else if (CW'(INDEX) == count) begin
            entry_in = tail_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;

endmodule
